/* src/bdss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdss_pkg
// Shared types and constants for the bus decoder with soft switches.
// ----------------------------------------------------------------------------
package bdss_pkg;

   localparam int STORE_DEPTH_DEF = 65536;

   localparam int ADDR_W   = 16;
   localparam int DATA_W   = 8;
   localparam int KEY_W    = 7;
   localparam int LIMIT_W  = 17;
   localparam int REQ_W    = 40;
   localparam int RSP_W    = 16;

   localparam logic [ADDR_W-1:0] KBD_DATA_ADDR   = 16'hC000;
   localparam logic [ADDR_W-1:0] KBD_STROBE_ADDR = 16'hC010;
   localparam logic [ADDR_W-1:0] SW_GRAPHICS     = 16'hC050;
   localparam logic [ADDR_W-1:0] SW_TEXT         = 16'hC051;
   localparam logic [ADDR_W-1:0] SW_PRIMARY      = 16'hC054;
   localparam logic [ADDR_W-1:0] SW_SECONDARY    = 16'hC055;
   localparam logic [ADDR_W-1:0] SW_LOW          = 16'hC056;
   localparam logic [ADDR_W-1:0] SW_HIGH         = 16'hC057;
   localparam logic [ADDR_W-1:0] IO_BASE         = 16'hC000;
   localparam logic [ADDR_W-1:0] ROM_BASE        = 16'hD000;
   localparam logic [ADDR_W-1:0] TEXT_FIRST      = 16'h0400;
   localparam logic [ADDR_W-1:0] TEXT_LAST       = 16'h0BFF;
   localparam logic [DATA_W-1:0] READY_BIT       = 8'h80;

   localparam logic [KEY_W-1:0] KEY_LINE_FEED = 7'd10;
   localparam logic [KEY_W-1:0] KEY_CR        = 7'd13;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

   typedef enum logic [2:0] {
      OP_READ   = 3'd0,
      OP_WRITE  = 3'd1,
      OP_KEY    = 3'd2,
      OP_ACK    = 3'd3,
      OP_LOAD   = 3'd4
   } opcode_type;

endpackage

/* src/bus_decoder_soft_switches.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bus_decoder_soft_switches
// Byte store with video soft switches, keyboard latch and render request.
//
// channel   dir  handshake              payload
// req       in   req_tvalid/req_tready  req_tdata  (opcode, address, data, key)
// rsp       out  rsp_tvalid/rsp_tready  rsp_tdata  (read data, success, flags)
// csr       in   csr_wr_en              csr_wr_data (memory_limit)
//
// one item per cycle sustained while rsp does not stall
// the single port store is read and written on the accept edge; the read byte
// is registered beside a holding stage, then both go into the output register
// stalls on rsp back up through the holding stage to req_tready
// synchronous reset clears the flags, the latch and both stages; store content
// is undefined until written
// ----------------------------------------------------------------------------
module bus_decoder_soft_switches #(
   parameter int STORE_DEPTH = bdss_pkg::STORE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // opcode[2:0], address[18:3], write_data[26:19], key_code[33:27], zero fill
   input  logic [bdss_pkg::REQ_W-1:0]    req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // read_data[7:0], success[8], graphics_mode[9], second_page[10],
   // high_resolution[11], render_pending[12], key_waiting[13], zero fill
   output logic [bdss_pkg::RSP_W-1:0]    rsp_tdata,
   input  logic                          csr_wr_en,
   input  logic [bdss_pkg::LIMIT_W-1:0]  csr_wr_data
);
   import bdss_pkg::*;

   localparam int IDX_W = $clog2(STORE_DEPTH);

   logic [DATA_W-1:0] store_mem [STORE_DEPTH];
   logic [DATA_W-1:0] mem_q_ff;

   logic [LIMIT_W-1:0] limit_ff;
   logic gfx_ff, page_ff, hires_ff, render_ff, ready_ff;
   logic gfx_in, page_in, hires_in, render_in, ready_in;
   logic [DATA_W-1:0] latch_ff, latch_in;

   logic              s1_valid_ff;
   logic              s1_mem_sel_ff;
   logic [DATA_W-1:0] s1_rdata_ff;
   logic [5:0]        s1_stat_ff;
   logic              s1_mem_sel_in;
   logic [DATA_W-1:0] s1_rdata_in;
   logic              ok_in;

   logic              rsp_valid_ff;
   logic [RSP_W-1:0]  rsp_data_ff;

   logic                s1_adv, req_acc;
   logic [2:0]          opcode;
   logic [ADDR_W-1:0]   address;
   logic [DATA_W-1:0]   wdata;
   logic [KEY_W-1:0]    key_code;
   logic                in_range, is_io, mem_re, mem_we;
   logic [IDX_W-1:0]    mem_idx;

   assign opcode   = req_tdata[2:0];
   assign address  = req_tdata[18:3];
   assign wdata    = req_tdata[26:19];
   assign key_code = req_tdata[33:27];
   assign mem_idx  = address[IDX_W-1:0];

   assign s1_adv     = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_acc    = req_tvalid && req_tready;

   assign in_range = {1'b0, address} < limit_ff;
   assign is_io    = (address >= IO_BASE) && (address < ROM_BASE);

   always_comb begin
      gfx_in        = gfx_ff;
      page_in       = page_ff;
      hires_in      = hires_ff;
      render_in     = render_ff;
      ready_in      = ready_ff;
      latch_in      = latch_ff;
      s1_rdata_in   = '0;
      s1_mem_sel_in = 1'b0;
      ok_in         = 1'b0;
      mem_re        = 1'b0;
      mem_we        = 1'b0;
      case (opcode)
         OP_READ: begin
            if (in_range) begin
               ok_in = 1'b1;
               case (address)
                  SW_GRAPHICS:     gfx_in   = 1'b1;
                  SW_TEXT:         gfx_in   = 1'b0;
                  SW_PRIMARY:      page_in  = 1'b0;
                  SW_SECONDARY:    page_in  = 1'b1;
                  SW_LOW:          hires_in = 1'b0;
                  SW_HIGH:         hires_in = 1'b1;
                  KBD_DATA_ADDR:   s1_rdata_in = ready_ff ? latch_ff : (latch_ff & ~READY_BIT);
                  KBD_STROBE_ADDR: ready_in = 1'b0;
                  default: begin
                     if (!is_io) begin
                        s1_mem_sel_in = 1'b1;
                        mem_re        = 1'b1;
                     end
                  end
               endcase
            end
         end
         OP_WRITE: begin
            if (in_range) begin
               ok_in = 1'b1;
               if (address >= TEXT_FIRST && address <= TEXT_LAST) begin
                  render_in = 1'b1;
               end
               if (address < IO_BASE) begin
                  mem_we = 1'b1;
               end
            end
         end
         OP_KEY: begin
            ok_in    = 1'b1;
            ready_in = 1'b1;
            latch_in = {1'b1, (key_code == KEY_LINE_FEED) ? KEY_CR : key_code};
         end
         OP_ACK: begin
            ok_in     = 1'b1;
            render_in = 1'b0;
         end
         OP_LOAD: begin
            if (in_range) begin
               ok_in  = 1'b1;
               mem_we = 1'b1;
            end
         end
         default: ok_in = 1'b0;
      endcase
   end

   // byte store, single port, registered read
   always_ff @(posedge clock) begin
      if (req_acc && mem_we) begin
         store_mem[mem_idx] <= wdata;
      end
      if (req_acc && mem_re) begin
         mem_q_ff <= store_mem[mem_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         gfx_ff       <= 1'b0;
         page_ff      <= 1'b0;
         hires_ff     <= 1'b0;
         render_ff    <= 1'b0;
         ready_ff     <= 1'b0;
         latch_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (req_acc) begin
            gfx_ff    <= gfx_in;
            page_ff   <= page_in;
            hires_ff  <= hires_in;
            render_ff <= render_in;
            ready_ff  <= ready_in;
            latch_ff  <= latch_in;
         end
         if (req_acc) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_mem_sel_ff <= s1_mem_sel_in;
         s1_rdata_ff   <= s1_rdata_in;
         s1_stat_ff    <= {ready_in, render_in, hires_in, page_in, gfx_in, ok_in};
      end
      if (s1_adv && s1_valid_ff) begin
         rsp_data_ff <= {2'b00, s1_stat_ff, s1_mem_sel_ff ? mem_q_ff : s1_rdata_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_stage_clear: assert property (@(posedge clock) reset |=> !s1_valid_ff && !rsp_valid_ff)
      else $error("stages not cleared by reset");

   a_key_ready: assert property (@(posedge clock) disable iff (reset)
      (req_acc && opcode == OP_KEY) |=> ready_ff && latch_ff[DATA_W-1])
      else $error("key press did not set ready");

   a_render_ack: assert property (@(posedge clock) disable iff (reset)
      (req_acc && opcode == OP_ACK) |=> !render_ff && s1_stat_ff[0])
      else $error("render acknowledge not taken");

   a_mem_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> $stable(mem_q_ff))
      else $error("store read data lost while stalled");

   a_out_range: assert property (@(posedge clock) disable iff (reset)
      (req_acc && !in_range && opcode != OP_KEY && opcode != OP_ACK)
      |=> !s1_stat_ff[0] && !s1_mem_sel_ff && s1_rdata_ff == '0)
      else $error("out of range access reported success");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bus decoder with soft switches. A directed table
// walks the keyboard latch, the strobe, every soft switch, text page writes,
// ROM and I/O drops, image loads and unused opcodes. Random bus traffic then
// runs under several memory limits, the extremes among them. Each item is
// predicted by a shadow of the store and flags, or given by the table, and
// each result is compared field by field. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
   import bdss_pkg::*;

   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
   localparam int NUM_DIRECTED   = 25;
   localparam int NUM_PHASES     = 8;
   localparam int PHASE_ITEMS    = 190;
   localparam int RANDOM_PHASE   = 5;

   typedef struct packed {
      logic [2:0]        opcode;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] write_data;
      logic [KEY_W-1:0]  key_code;
   } bus_item_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              success;
      logic              graphics_mode;
      logic              second_page;
      logic              high_resolution;
      logic              render_pending;
      logic              key_waiting;
   } bus_status_type;

   typedef struct packed {
      bus_item_type   item;
      logic           literal;
      bus_status_type status;
   } dir_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               csr_wr_en = 1'b0;
   logic [LIMIT_W-1:0] csr_wr_data = '0;

   // shadow of the block
   logic [DATA_W-1:0]  shadow_mem [STORE_DEPTH_DEF];
   bit                 shadow_written [STORE_DEPTH_DEF];
   logic [ADDR_W-1:0]  written_addrs [$];
   logic [LIMIT_W-1:0] mem_limit = LIMIT_RESET;
   logic               gfx_sw = 1'b0;
   logic               page_sw = 1'b0;
   logic               hires_sw = 1'b0;
   logic [DATA_W-1:0]  key_latch = '0;
   logic               key_ready = 1'b0;
   logic               render_req = 1'b0;

   bus_status_type     pending_status [$];
   int                 mismatches = 0;
   bit                 idle_on = 1'b1;

   logic [ADDR_W-1:0]  hot_addrs [8] = '{KBD_DATA_ADDR, KBD_STROBE_ADDR, SW_GRAPHICS, SW_TEXT,
                                         SW_PRIMARY, SW_SECONDARY, SW_LOW, SW_HIGH};
   logic [LIMIT_W-1:0] phase_limits [NUM_PHASES] = '{LIMIT_RESET, 17'h00000, 17'h00C00,
                                                     17'h0C000, 17'h0FFFF, LIMIT_RESET,
                                                     17'h00001, LIMIT_RESET};

   dir_row_type directed_rows [NUM_DIRECTED] = '{
      '{'{OP_READ, KBD_DATA_ADDR, 8'h00, 7'h00}, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{'{OP_SPARE_FIRST, 16'hFFFF, 8'hFF, 7'h7F}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{'{OP_SPARE_LAST, 16'h0000, 8'h00, 7'h00}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{'{OP_KEY, 16'h0000, 8'h00, KEY_LINE_FEED}, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{'{OP_READ, KBD_DATA_ADDR, 8'h00, 7'h00}, 1'b1, '{8'h8D, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{'{OP_READ, KBD_STROBE_ADDR, 8'h00, 7'h00}, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{'{OP_READ, KBD_DATA_ADDR, 8'h00, 7'h00}, 1'b1, '{8'h0D, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{'{OP_KEY, 16'h0000, 8'h00, 7'h7F}, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{'{OP_WRITE, TEXT_FIRST, 8'hFF, 7'h00}, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1}},
      '{'{OP_ACK, 16'h0000, 8'h00, 7'h00}, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{'{OP_READ, TEXT_FIRST, 8'h00, 7'h00}, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{'{OP_WRITE, TEXT_LAST, 8'h00, 7'h00}, 1'b0, '0},
      '{'{OP_WRITE, 16'h0C00, 8'h5A, 7'h00}, 1'b0, '0},
      '{'{OP_WRITE, IO_BASE, 8'h12, 7'h00}, 1'b0, '0},
      '{'{OP_WRITE, ROM_BASE, 8'h34, 7'h00}, 1'b0, '0},
      '{'{OP_LOAD, 16'hFFFF, 8'h80, 7'h00}, 1'b0, '0},
      '{'{OP_LOAD, ROM_BASE, 8'h7E, 7'h00}, 1'b0, '0},
      '{'{OP_READ, 16'hFFFF, 8'h00, 7'h00}, 1'b0, '0},
      '{'{OP_READ, ROM_BASE, 8'h00, 7'h00}, 1'b0, '0},
      '{'{OP_READ, SW_GRAPHICS, 8'h00, 7'h00}, 1'b0, '0},
      '{'{OP_READ, SW_SECONDARY, 8'h00, 7'h00}, 1'b0, '0},
      '{'{OP_READ, SW_HIGH, 8'h00, 7'h00}, 1'b0, '0},
      '{'{OP_READ, SW_TEXT, 8'h00, 7'h00}, 1'b0, '0},
      '{'{OP_READ, SW_PRIMARY, 8'h00, 7'h00}, 1'b0, '0},
      '{'{OP_READ, SW_LOW, 8'h00, 7'h00}, 1'b0, '0}
   };

   bus_decoder_soft_switches dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit is_store_addr(input logic [ADDR_W-1:0] a);
      return (a >= ROM_BASE) || (a < IO_BASE);
   endfunction

   function automatic void store_byte(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
      shadow_mem[a] = d;
      if (!shadow_written[a]) begin
         shadow_written[a] = 1'b1;
         written_addrs.push_back(a);
      end
   endfunction

   // applies one item to the shadow state and returns the status it produces
   function automatic bus_status_type apply_bus_access(input bus_item_type it);
      bus_status_type st;
      logic        in_range;
      logic [KEY_W-1:0] key;
      st = '0;
      in_range = {1'b0, it.address} < mem_limit;
      key = it.key_code;
      case (it.opcode)
         OP_READ: begin
            if (in_range) begin
               st.success = 1'b1;
               case (it.address)
                  SW_GRAPHICS:     gfx_sw = 1'b1;
                  SW_TEXT:         gfx_sw = 1'b0;
                  SW_PRIMARY:      page_sw = 1'b0;
                  SW_SECONDARY:    page_sw = 1'b1;
                  SW_LOW:          hires_sw = 1'b0;
                  SW_HIGH:         hires_sw = 1'b1;
                  KBD_DATA_ADDR:   st.read_data = key_ready ? key_latch : key_latch & ~READY_BIT;
                  KBD_STROBE_ADDR: key_ready = 1'b0;
                  default: begin
                     if (is_store_addr(it.address)) st.read_data = shadow_mem[it.address];
                  end
               endcase
            end
         end
         OP_WRITE: begin
            if (in_range) begin
               st.success = 1'b1;
               if (it.address >= TEXT_FIRST && it.address <= TEXT_LAST) render_req = 1'b1;
               if (it.address < IO_BASE) store_byte(it.address, it.write_data);
            end
         end
         OP_KEY: begin
            if (key == KEY_LINE_FEED) key = KEY_CR;
            key_latch = {1'b0, key} | READY_BIT;
            key_ready = 1'b1;
            st.success = 1'b1;
         end
         OP_ACK: begin
            render_req = 1'b0;
            st.success = 1'b1;
         end
         OP_LOAD: begin
            if (in_range) begin
               st.success = 1'b1;
               store_byte(it.address, it.write_data);
            end
         end
         default: ;
      endcase
      st.graphics_mode = gfx_sw;
      st.second_page = page_sw;
      st.high_resolution = hires_sw;
      st.render_pending = render_req;
      st.key_waiting = key_ready;
      return st;
   endfunction

   function automatic logic [ADDR_W-1:0] pick_address();
      logic [LIMIT_W-1:0] edge_addr;
      case ($urandom_range(0, 9))
         0, 1: return TEXT_FIRST + ADDR_W'($urandom_range(0, 16'h07FF));
         2:    return hot_addrs[$urandom_range(0, 7)];
         3:    return IO_BASE + ADDR_W'($urandom_range(0, 16'h0FFF));
         4:    return ROM_BASE + ADDR_W'($urandom_range(0, 16'h2FFF));
         5: begin
            edge_addr = (mem_limit == 0) ? '0 : mem_limit - LIMIT_W'($urandom_range(0, 1));
            return edge_addr[ADDR_W-1:0];
         end
         default: return ADDR_W'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   function automatic bus_item_type random_item();
      bus_item_type it;
      int        r;
      r = $urandom_range(0, 99);
      it.write_data = DATA_W'($urandom_range(0, 255));
      it.key_code = ($urandom_range(0, 3) == 0) ? KEY_LINE_FEED : KEY_W'($urandom_range(0, 127));
      it.address = pick_address();
      if (r < 35) it.opcode = OP_READ;
      else if (r < 60) it.opcode = OP_WRITE;
      else if (r < 72) it.opcode = OP_LOAD;
      else if (r < 84) it.opcode = OP_KEY;
      else if (r < 92) it.opcode = OP_ACK;
      else it.opcode = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      if (it.opcode == OP_READ) begin
         if (written_addrs.size() != 0 && $urandom_range(0, 9) < 4)
            it.address = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
         // never read a store byte that holds nothing yet
         if (is_store_addr(it.address) && {1'b0, it.address} < mem_limit &&
             !shadow_written[it.address]) begin
            if (written_addrs.size() != 0)
               it.address = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
            else
               it.address = KBD_DATA_ADDR;
         end
      end
      return it;
   endfunction

   task automatic send_item(input bus_item_type it, input logic literal,
                            input bus_status_type typed);
      int gap;
      bus_status_type st;
      gap = idle_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, it.key_code, it.write_data, it.address, it.opcode};
      do @(posedge clock); while (!req_tready);
      st = apply_bus_access(it);
      pending_status.push_back(literal ? typed : st);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_limit(input logic [LIMIT_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      mem_limit = value;
   endtask

   task automatic report_field(input string field, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
         mismatches++;
      end
   endtask

   // result side: random stall per item
   initial begin : rsp_side
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = idle_on ? $urandom_range(0, 8) : 0;
         if (stall > 0) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin : check_rsp
      bus_status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_status.size() == 0) begin
            $display("%0t: unexpected item, expected none, got %h", $time, rsp_tdata);
            mismatches++;
         end else begin
            want = pending_status.pop_front();
            report_field("read_data", want.read_data, rsp_tdata[7:0]);
            report_field("success", 8'(want.success), 8'(rsp_tdata[8]));
            report_field("graphics_mode", 8'(want.graphics_mode), 8'(rsp_tdata[9]));
            report_field("second_page", 8'(want.second_page), 8'(rsp_tdata[10]));
            report_field("high_resolution", 8'(want.high_resolution), 8'(rsp_tdata[11]));
            report_field("render_pending", 8'(want.render_pending), 8'(rsp_tdata[12]));
            report_field("key_waiting", 8'(want.key_waiting), 8'(rsp_tdata[13]));
         end
      end
   end

   initial begin : stimulus
      logic [LIMIT_W-1:0] lim;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_limit(LIMIT_RESET);
      for (int i = 0; i < NUM_DIRECTED; i++)
         send_item(directed_rows[i].item, directed_rows[i].literal, directed_rows[i].status);
      drain();
      for (int p = 0; p < NUM_PHASES; p++) begin
         lim = (p == RANDOM_PHASE) ? LIMIT_W'($urandom_range(0, 65536)) : phase_limits[p];
         set_limit(lim);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
            send_item(random_item(), 1'b0, '0);
         end
         drain();
      end
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending_status.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin : watchdog
      #(3_000_000);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
